>>> rtl/mkd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mkd_pkg;

   localparam int MAX_SYMBOLS = 5;
   localparam int TIME_BITS   = 16;
   localparam int CFG_BITS    = 16;
   localparam int CNT_BITS    = $clog2(MAX_SYMBOLS + 1);
   localparam int NUM_CODES   = 36;
   localparam int NUM_LETTERS = 26;
   localparam int CHAR_BITS   = 7;

   localparam logic [1:0] FUNC_PRESS   = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_CHECK   = 2'd2;

   localparam logic [1:0] KIND_DOT  = 2'd0;
   localparam logic [1:0] KIND_DASH = 2'd1;
   localparam logic [1:0] KIND_CHAR = 2'd2;

   localparam logic [1:0] CSR_DOT_MIN   = 2'd0;
   localparam logic [1:0] CSR_DOT_MAX   = 2'd1;
   localparam logic [1:0] CSR_DASH_MAX  = 2'd2;
   localparam logic [1:0] CSR_GAP_TICKS = 2'd3;

   localparam logic [CFG_BITS-1:0] DOT_MIN_RESET   = 16'd468;
   localparam logic [CFG_BITS-1:0] DOT_MAX_RESET   = 16'd3000;
   localparam logic [CFG_BITS-1:0] DASH_MAX_RESET  = 16'd6250;
   localparam logic [CFG_BITS-1:0] GAP_TICKS_RESET = 16'd45000;

   localparam logic [CHAR_BITS-1:0] CHAR_A    = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'h30;

   // A-Z then 0-9; bit i is symbol i, 1 = dash
   localparam logic [CNT_BITS-1:0] CODE_LEN [NUM_CODES] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5};

   localparam logic [MAX_SYMBOLS-1:0] CODE_BITS [NUM_CODES] = '{
      5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
      5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
      5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15};

   typedef enum logic [1:0] {
      OP_DOT,
      OP_DASH,
      OP_GAP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [CHAR_BITS-1:0] character;
      logic                 lamp_dot;
      logic                 lamp_dash;
   } rsp_type;

   typedef struct packed {
      logic                 hit;
      logic [CHAR_BITS-1:0] character;
   } lookup_type;

   function automatic lookup_type code_lookup(input logic [CNT_BITS-1:0]    count,
                                              input logic [MAX_SYMBOLS-1:0] pattern);
      lookup_type res;
      res.hit       = 1'b0;
      res.character = '0;
      // walk downward so the lowest matching entry wins
      for (int i = NUM_CODES - 1; i >= 0; i--) begin
         if (CODE_LEN[i] == count && CODE_BITS[i] == pattern) begin
            res.hit = 1'b1;
            if (i < NUM_LETTERS) begin
               res.character = CHAR_A + CHAR_BITS'(i);
            end else begin
               res.character = CHAR_ZERO + CHAR_BITS'(i - NUM_LETTERS);
            end
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> rtl/mkd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mkd_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire logic [1:0]                      req_func,
   input  wire logic [mkd_pkg::TIME_BITS-1:0]   req_timestamp,
   input  wire logic                            csr_write_enable,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [mkd_pkg::CFG_BITS-1:0]    csr_data,
   input  wire logic                            cmd_full,
   output      logic                            cmd_push,
   output      mkd_pkg::cmd_type                cmd
);
   import mkd_pkg::*;

   logic [CFG_BITS-1:0]  dot_min_ff, dot_max_ff, dash_max_ff, gap_ticks_ff;
   logic [TIME_BITS-1:0] press_time_ff, press_time_in;
   logic [TIME_BITS-1:0] release_time_ff, release_time_in;
   logic [TIME_BITS-1:0] hold, elapsed;
   logic                 accept, is_dot, is_dash, is_gap;

   assign accept  = req_push && !cmd_full;
   assign hold    = req_timestamp - press_time_ff;
   assign elapsed = req_timestamp - release_time_ff;
   assign is_dot  = hold >= TIME_BITS'(dot_min_ff) && hold <= TIME_BITS'(dot_max_ff);
   assign is_dash = hold > TIME_BITS'(dot_max_ff) && hold <= TIME_BITS'(dash_max_ff);
   assign is_gap  = elapsed > TIME_BITS'(gap_ticks_ff);

   always_comb begin
      press_time_in   = press_time_ff;
      release_time_in = release_time_ff;
      cmd_push        = 1'b0;
      cmd.op          = OP_DOT;
      if (accept) begin
         unique case (req_func)
            FUNC_PRESS: begin
               press_time_in = req_timestamp;
            end
            FUNC_RELEASE: begin
               release_time_in = req_timestamp;
               if (is_dot) begin
                  cmd_push = 1'b1;
                  cmd.op   = OP_DOT;
               end else if (is_dash) begin
                  cmd_push = 1'b1;
                  cmd.op   = OP_DASH;
               end
            end
            FUNC_CHECK: begin
               if (is_gap) begin
                  release_time_in = req_timestamp;
                  cmd_push        = 1'b1;
                  cmd.op          = OP_GAP;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_time_ff   <= '0;
         release_time_ff <= '0;
         dot_min_ff      <= DOT_MIN_RESET;
         dot_max_ff      <= DOT_MAX_RESET;
         dash_max_ff     <= DASH_MAX_RESET;
         gap_ticks_ff    <= GAP_TICKS_RESET;
      end else begin
         press_time_ff   <= press_time_in;
         release_time_ff <= release_time_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DOT_MIN:   dot_min_ff   <= csr_data;
               CSR_DOT_MAX:   dot_max_ff   <= csr_data;
               CSR_DASH_MAX:  dash_max_ff  <= csr_data;
               CSR_GAP_TICKS: gap_ticks_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/mkd_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mkd_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mkd_pkg::cmd_type  wdata,
   output      logic              full,
   input  wire logic              pop,
   output      logic              empty,
   output      mkd_pkg::cmd_type  rdata
);
   import mkd_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule
`default_nettype wire

>>> rtl/mkd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mkd_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            cmd_empty,
   input  wire mkd_pkg::cmd_type                cmd,
   output      logic                            cmd_pop,
   output      logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   output      logic [1:0]                      rsp_kind,
   output      logic [mkd_pkg::CHAR_BITS-1:0]   rsp_character,
   output      logic                            rsp_lamp_dot,
   output      logic                            rsp_lamp_dash
);
   import mkd_pkg::*;

   logic [MAX_SYMBOLS-1:0] pattern_ff, pattern_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   overflowed_ff, overflowed_in;
   logic [1:0]             lamps_ff, lamps_in;
   lookup_type             found;
   logic                   emit;
   rsp_type                beat;

   rsp_type                out_mem_ff [2];
   logic                   out_wr_ff, out_rd_ff;
   logic [1:0]             out_count_ff;
   logic                   out_pop;

   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_empty = out_count_ff == 2'd0;
   assign cmd_pop   = !cmd_empty && (out_count_ff != 2'd2 || out_pop);
   assign found     = code_lookup(count_ff, pattern_ff);

   always_comb begin
      pattern_in     = pattern_ff;
      count_in       = count_ff;
      overflowed_in  = overflowed_ff;
      lamps_in       = lamps_ff;
      emit           = 1'b0;
      beat.kind      = KIND_DOT;
      beat.character = '0;
      if (cmd_pop) begin
         unique case (cmd.op)
            OP_DOT, OP_DASH: begin
               if (count_ff < CNT_BITS'(MAX_SYMBOLS)) begin
                  pattern_in = pattern_ff
                             | (MAX_SYMBOLS'(cmd.op == OP_DASH) << count_ff);
                  count_in   = count_ff + 1'b1;
               end else begin
                  overflowed_in = 1'b1;
               end
               lamps_in  = (cmd.op == OP_DASH) ? 2'b10 : 2'b01;
               emit      = 1'b1;
               beat.kind = (cmd.op == OP_DASH) ? KIND_DASH : KIND_DOT;
            end
            OP_GAP: begin
               pattern_in     = '0;
               count_in       = '0;
               overflowed_in  = 1'b0;
               emit           = found.hit && !overflowed_ff && count_ff != '0;
               beat.kind      = KIND_CHAR;
               beat.character = found.character;
            end
            default: begin
            end
         endcase
      end
      beat.lamp_dot  = lamps_in[0];
      beat.lamp_dash = lamps_in[1];
   end

   assign rsp_kind      = out_mem_ff[out_rd_ff].kind;
   assign rsp_character = out_mem_ff[out_rd_ff].character;
   assign rsp_lamp_dot  = out_mem_ff[out_rd_ff].lamp_dot;
   assign rsp_lamp_dash = out_mem_ff[out_rd_ff].lamp_dash;

   always_ff @(posedge clock) begin
      if (emit) begin
         out_mem_ff[out_wr_ff] <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff    <= '0;
         count_ff      <= '0;
         overflowed_ff <= 1'b0;
         lamps_ff      <= 2'b00;
         out_wr_ff     <= 1'b0;
         out_rd_ff     <= 1'b0;
         out_count_ff  <= 2'd0;
      end else begin
         pattern_ff    <= pattern_in;
         count_ff      <= count_in;
         overflowed_ff <= overflowed_in;
         lamps_ff      <= lamps_in;
         if (emit) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= ~out_rd_ff;
         end
         out_count_ff <= out_count_ff + 2'(emit) - 2'(out_pop);
      end
   end

endmodule
`default_nettype wire

>>> rtl/morse_key_timing_decoder_core.sv
// Each result beat passes through the command queue register between the front and back
// stages and then through the result queue register before it reaches the rsp_ ports.
// Throughput: one event per cycle; the front stage and the two-entry command queue
// take an event every cycle while the back stage and the two-entry result queue drain.
// Reset (synchronous, active high) empties both queues, clears key timing and the
// symbol store, turns both lamps off and restores the four timing registers.
`timescale 1ns / 1ps
`default_nettype none
module morse_key_timing_decoder_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output      logic                            req_full,
   input  wire logic [1:0]                      req_func,
   input  wire logic [mkd_pkg::TIME_BITS-1:0]   req_timestamp,
   output      logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   output      logic [1:0]                      rsp_kind,
   output      logic [mkd_pkg::CHAR_BITS-1:0]   rsp_character,
   output      logic                            rsp_lamp_dot,
   output      logic                            rsp_lamp_dash,
   input  wire logic                            csr_write_enable,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [mkd_pkg::CFG_BITS-1:0]    csr_data
);
   import mkd_pkg::*;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_wdata, cmd_rdata;

   assign req_full = cmd_full;

   mkd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_func         (req_func),
      .req_timestamp    (req_timestamp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd_full         (cmd_full),
      .cmd_push         (cmd_push),
      .cmd              (cmd_wdata)
   );

   mkd_cmd_queue u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (cmd_rdata)
   );

   mkd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (cmd_empty),
      .cmd           (cmd_rdata),
      .cmd_pop       (cmd_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_kind      (rsp_kind),
      .rsp_character (rsp_character),
      .rsp_lamp_dot  (rsp_lamp_dot),
      .rsp_lamp_dash (rsp_lamp_dash)
   );

endmodule
`default_nettype wire

>>> tb/tb_morse_key_timing_decoder_core.sv
`timescale 1ns / 1ps
module tb_morse_key_timing_decoder_core;
   import mkd_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [1:0]           req_func = FUNC_PRESS;
   logic [TIME_BITS-1:0] req_timestamp = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [1:0]           rsp_kind;
   logic [CHAR_BITS-1:0] rsp_character;
   logic                 rsp_lamp_dot;
   logic                 rsp_lamp_dash;
   logic                 csr_write_enable = 1'b0;
   logic [1:0]           csr_index = CSR_DOT_MIN;
   logic [CFG_BITS-1:0]  csr_data = '0;

   morse_key_timing_decoder_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_timestamp    (req_timestamp),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_character    (rsp_character),
      .rsp_lamp_dot     (rsp_lamp_dot),
      .rsp_lamp_dash    (rsp_lamp_dash),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // letters then digits, dot and dash as keyed
   string morse_text [36] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---", "-.-",
      ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-", "..-", "...-",
      ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...", "---..",
      "----."};
   string glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
   logic [2:0] morse_len [36];
   logic [4:0] morse_pat [36];

   logic [CFG_BITS-1:0]    dot_lo  = DOT_MIN_RESET;
   logic [CFG_BITS-1:0]    dot_hi  = DOT_MAX_RESET;
   logic [CFG_BITS-1:0]    dash_hi = DASH_MAX_RESET;
   logic [CFG_BITS-1:0]    gap_len = GAP_TICKS_RESET;
   logic [TIME_BITS-1:0]   press_at = '0;
   logic [TIME_BITS-1:0]   last_release = '0;
   logic [MAX_SYMBOLS-1:0] sym_bits = '0;
   logic [2:0]             sym_count = '0;
   logic                   sym_overflow = 1'b0;
   logic                   lamp_dot_on = 1'b0;
   logic                   lamp_dash_on = 1'b0;

   rsp_type pending_beats [$];
   rsp_type next_beat;
   int      fail_count = 0;
   int      events_sent = 0;
   bit      idle_on = 1'b1;
   int      pop_hold = 0;
   int      pop_wait = 0;
   logic [TIME_BITS-1:0] now_tick = '0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      for (int i = 0; i < 36; i++) begin
         morse_len[i] = 3'(morse_text[i].len());
         morse_pat[i] = '0;
         for (int k = 0; k < morse_text[i].len(); k++) begin
            morse_pat[i][k] = (morse_text[i][k] == "-");
         end
      end
   end

   function automatic int idle_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   function automatic void store_symbol(input logic is_dash);
      if (sym_count < MAX_SYMBOLS) begin
         sym_bits[sym_count] = is_dash;
         sym_count++;
      end else begin
         sym_overflow = 1'b1;
      end
   endfunction

   function automatic void decode_event(input logic [1:0] f, input logic [TIME_BITS-1:0] ts);
      logic [TIME_BITS-1:0] span;
      rsp_type              beat;
      int                   hit;
      beat = '0;
      hit = -1;
      case (f)
         FUNC_PRESS: press_at = ts;
         FUNC_RELEASE: begin
            last_release = ts;
            span = ts - press_at;
            if (span >= dot_lo && span <= dot_hi) begin
               store_symbol(1'b0);
               lamp_dot_on = 1'b1;
               lamp_dash_on = 1'b0;
               beat.kind = KIND_DOT;
               beat.lamp_dot = 1'b1;
               pending_beats.push_back(beat);
            end else if (span > dot_hi && span <= dash_hi) begin
               store_symbol(1'b1);
               lamp_dot_on = 1'b0;
               lamp_dash_on = 1'b1;
               beat.kind = KIND_DASH;
               beat.lamp_dash = 1'b1;
               pending_beats.push_back(beat);
            end
         end
         FUNC_CHECK: begin
            span = ts - last_release;
            if (span > gap_len) begin
               if (!sym_overflow && sym_count != 0) begin
                  for (int i = 0; i < 36; i++) begin
                     if (hit < 0 && morse_len[i] == sym_count && morse_pat[i] == sym_bits)
                        hit = i;
                  end
               end
               sym_bits = '0;
               sym_count = '0;
               sym_overflow = 1'b0;
               last_release = ts;
               if (hit >= 0) begin
                  beat.kind = KIND_CHAR;
                  beat.character = 7'(glyphs[hit]);
                  beat.lamp_dot = lamp_dot_on;
                  beat.lamp_dash = lamp_dash_on;
                  pending_beats.push_back(beat);
               end
            end
         end
         default: ;
      endcase
   endfunction

   initial begin
      forever begin
         @(negedge clock);
         if (pop_hold > 0) begin
            rsp_pop <= 1'b0;
            pop_hold--;
         end else if (pop_wait > 0) begin
            rsp_pop <= 1'b0;
            pop_wait--;
         end else begin
            rsp_pop <= 1'b1;
            pop_wait = idle_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_beats.size() == 0) begin
            log_failure($sformatf("unexpected beat: kind=%0d char=%02h dot=%0b dash=%0b",
                                  rsp_kind, rsp_character, rsp_lamp_dot, rsp_lamp_dash));
         end else begin
            next_beat = pending_beats.pop_front();
            if (rsp_kind !== next_beat.kind || rsp_character !== next_beat.character ||
                rsp_lamp_dot !== next_beat.lamp_dot ||
                rsp_lamp_dash !== next_beat.lamp_dash) begin
               log_failure($sformatf(
                  "beat mismatch: expected kind=%0d char=%02h dot=%0b dash=%0b, got kind=%0d char=%02h dot=%0b dash=%0b",
                  next_beat.kind, next_beat.character, next_beat.lamp_dot, next_beat.lamp_dash,
                  rsp_kind, rsp_character, rsp_lamp_dot, rsp_lamp_dash));
            end
         end
      end
   end

   task automatic send_event(input logic [1:0] f, input logic [TIME_BITS-1:0] ts);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_func <= f;
      req_timestamp <= ts;
      @(posedge clock);
      while (req_full) @(posedge clock);
      decode_event(f, ts);
      if (f != FUNC_UNUSED) events_sent++;
   endtask

   // drop the input, wait for every result, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      case (idx)
         CSR_DOT_MIN:  dot_lo = val;
         CSR_DOT_MAX:  dot_hi = val;
         CSR_DASH_MAX: dash_hi = val;
         default:      gap_len = val;
      endcase
   endtask

   task automatic program_timing(input logic [CFG_BITS-1:0] lo, input logic [CFG_BITS-1:0] hi,
                                 input logic [CFG_BITS-1:0] dash, input logic [CFG_BITS-1:0] gap);
      settle();
      write_csr(CSR_DOT_MIN, lo);
      write_csr(CSR_DOT_MAX, hi);
      write_csr(CSR_DASH_MAX, dash);
      write_csr(CSR_GAP_TICKS, gap);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [TIME_BITS-1:0] pick_hold(input logic want_dash);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'($urandom);
      if (!want_dash) begin
         if (r == 1) return dot_lo;
         if (r == 2) return dot_hi;
         if (dot_lo <= dot_hi) return 16'($urandom_range(dot_hi, dot_lo));
      end else begin
         if (r == 1) return dot_hi + 16'd1;
         if (r == 2) return dash_hi;
         if (r == 3) return dash_hi + 16'd1;
         if (dot_hi < dash_hi) return 16'($urandom_range(dash_hi, dot_hi + 1));
      end
      return 16'($urandom);
   endfunction

   task automatic key_stroke(input logic [TIME_BITS-1:0] hold);
      send_event(FUNC_PRESS, now_tick);
      send_event(FUNC_RELEASE, now_tick + hold);
      now_tick = now_tick + hold + 16'($urandom_range(1, 4000));
   endtask

   task automatic end_character();
      logic [TIME_BITS-1:0] ts;
      int                   room;
      if (gap_len == 16'hFFFF) begin
         ts = 16'($urandom);
      end else begin
         room = 65534 - gap_len;
         ts = last_release + gap_len + 16'd1 +
              16'($urandom_range(0, room < 3000 ? room : 3000));
      end
      send_event(FUNC_CHECK, ts);
      now_tick = ts + 16'($urandom_range(1, 3000));
   endtask

   task automatic send_character();
      int         mode;
      int         len;
      int         pick;
      logic [7:0] bits;
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
         pick = $urandom_range(0, 35);
         len = morse_len[pick];
         bits = 8'(morse_pat[pick]);
      end else if (mode < 9) begin
         len = $urandom_range(1, 5);
         bits = 8'($urandom);
      end else begin
         len = $urandom_range(6, 7);
         bits = 8'($urandom);
      end
      for (int k = 0; k < len; k++) key_stroke(pick_hold(bits[k]));
      end_character();
   endtask

   task automatic random_traffic(input int count);
      int target;
      target = events_sent + count;
      while (events_sent < target) begin
         case ($urandom_range(0, 9))
            0:       send_event(2'($urandom), 16'($urandom));
            1:       send_event(FUNC_CHECK, last_release + 16'($urandom_range(0, 300)));
            default: send_character();
         endcase
      end
   endtask

   task automatic test_directed();
      send_event(FUNC_PRESS, 16'hFFFF);
      send_event(FUNC_RELEASE, 16'd999);
      send_event(FUNC_PRESS, 16'd0);
      send_event(FUNC_RELEASE, 16'd4000);
      send_event(FUNC_UNUSED, 16'hFFFF);
      send_event(FUNC_CHECK, 16'd49000);
      send_event(FUNC_CHECK, 16'd49001);
      send_event(FUNC_CHECK, 16'd28466);
      send_event(FUNC_PRESS, 16'd30000);
      send_event(FUNC_RELEASE, 16'd30100);
      send_event(FUNC_PRESS, 16'd31000);
      send_event(FUNC_RELEASE, 16'd38000);
      send_event(FUNC_CHECK, 16'd17465);
      now_tick = 16'd20000;
      for (int k = 0; k < 6; k++) key_stroke(k == 5 ? dot_hi : dot_lo);
      end_character();
   endtask

   task automatic test_default_timing();
      random_traffic(150);
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      random_traffic(60);
      idle_on = 1'b1;
   endtask

   task automatic test_result_stall();
      settle();
      pop_hold = 100;
      idle_on = 1'b0;
      for (int k = 0; k < 15; k++) key_stroke(pick_hold(k[0]));
      idle_on = 1'b1;
      end_character();
   endtask

   task automatic test_timing_sweep();
      program_timing(16'd100, 16'd400, 16'd900, 16'd2000);
      random_traffic(60);
      program_timing(16'd0, 16'd0, 16'd0, 16'd0);
      random_traffic(60);
      program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_traffic(60);
      program_timing(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      random_traffic(60);
      program_timing(16'd5000, 16'd3000, 16'd2000, 16'd300);
      random_traffic(60);
      program_timing(16'd1, 16'd2, 16'hFFFF, 16'd30000);
      random_traffic(60);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_default_timing();
      test_back_to_back();
      test_result_stall();
      test_timing_sweep();
      settle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/mkd_pkg.sv
rtl/mkd_front.sv
rtl/mkd_cmd_queue.sv
rtl/mkd_back.sv
rtl/morse_key_timing_decoder_core.sv
tb/tb_morse_key_timing_decoder_core.sv
